[rtl/bitd_pkg.sv]
package bitd_pkg;

	localparam int SAMPLE_W = 24;
	localparam int TIME_W = 32;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 4;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_IMPACT_OFFSET  = 2'd0,
		REG_RELEASE_OFFSET = 2'd1,
		REG_DEBOUNCE_US    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] impact_offset;
		logic [SAMPLE_W-1:0] release_offset;
		logic [TIME_W-1:0]   debounce_us;
	} cfg_t;

	typedef struct packed {
		logic impact;
		logic release_ev;
	} ev_t;

endpackage

[rtl/bitd_event.sv]
module bitd_event #(
	parameter int CHANNELS = 2,
	parameter int CH_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bitd_pkg::cfg_t                cfg,
	input  logic                          commit,
	input  logic [CH_W-1:0]               ch,
	input  logic [bitd_pkg::SAMPLE_W-1:0] sample,
	input  logic [bitd_pkg::SAMPLE_W-1:0] avg,
	input  logic [bitd_pkg::TIME_W-1:0]   now,
	output bitd_pkg::ev_t                 ev
);

	localparam int CMP_W = bitd_pkg::SAMPLE_W + 1;

	logic [bitd_pkg::TIME_W-1:0] last_q [CHANNELS];
	logic [bitd_pkg::TIME_W-1:0] elapsed;
	logic                        settled;
	logic                        imp_hit;
	logic                        rel_hit;

	// elapsed wraps modulo 2^32
	assign elapsed = now - last_q[ch];
	assign settled = elapsed > cfg.debounce_us;

	// sample > avg + offset, compared one bit wider
	assign imp_hit = CMP_W'(sample) > (CMP_W'(avg) + CMP_W'(cfg.impact_offset));
	// sample < avg - offset (saturating at zero) rewritten without the subtract
	assign rel_hit = (CMP_W'(sample) + CMP_W'(cfg.release_offset)) < CMP_W'(avg);

	always_comb begin
		ev.impact     = settled && imp_hit;
		ev.release_ev = settled && !imp_hit && rel_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_q[i] <= '0;
			end
		end else if (commit && (ev.impact || ev.release_ev)) begin
			last_q[ch] <= now;
		end
	end

endmodule

[rtl/baseline_tracking_impact_detector_core.sv]
// channel | handshake             | payload
// --------+-----------------------+---------------------------------------------------------
// in      | in_valid / in_stall   | channel, sample, time_us
// out     | out_valid / out_stall | out_channel, current_value, average, impact, release_res
// cfg     | apb (psel, penable)   | paddr, pwdata, prdata, pready tied high
//
// one request per cycle sustained while out_stall is low; each request takes the window read
// into stage one, the sum update into stage two and the compare into the output register
// the rate is set by the window memory: one read of the oldest entry and one write per cycle
// reset clears positions, sums, fill flags and event times; an entry not yet written since
// reset reads as zero through the per-channel fill flag, so no clearing pass is run
// out_stall backs up through the stages; in_stall rises only when stage one cannot move on
module baseline_tracking_impact_detector_core #(
	parameter int WINDOW_DEPTH = 2048,
	parameter int CHANNELS = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bitd_pkg::PADDR_W-1:0]   paddr,
	input  logic [bitd_pkg::DATA_W-1:0]    pwdata,
	output logic [bitd_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	// sample requests
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           channel,
	input  logic [bitd_pkg::SAMPLE_W-1:0]  sample,
	input  logic [bitd_pkg::TIME_W-1:0]    time_us,
	// results
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           out_channel,
	output logic [bitd_pkg::SAMPLE_W-1:0]  current_value,
	output logic [bitd_pkg::SAMPLE_W-1:0]  average,
	output logic                           impact,
	output logic                           release_res
);

	localparam int POS_W = $clog2(WINDOW_DEPTH);
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W = CH_W + POS_W;
	localparam int MEM_DEPTH = CHANNELS * WINDOW_DEPTH;
	localparam int SUM_W = bitd_pkg::SAMPLE_W + POS_W;

	// ---------------------------------------------------------------- config
	bitd_pkg::cfg_t   cfg_q;
	bitd_pkg::reg_idx_t reg_idx;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = bitd_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				bitd_pkg::REG_IMPACT_OFFSET: begin
					cfg_q.impact_offset <= pwdata[bitd_pkg::SAMPLE_W-1:0];
				end
				bitd_pkg::REG_RELEASE_OFFSET: begin
					cfg_q.release_offset <= pwdata[bitd_pkg::SAMPLE_W-1:0];
				end
				bitd_pkg::REG_DEBOUNCE_US: begin
					cfg_q.debounce_us <= pwdata[bitd_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bitd_pkg::REG_IMPACT_OFFSET:  prdata = bitd_pkg::DATA_W'(cfg_q.impact_offset);
			bitd_pkg::REG_RELEASE_OFFSET: prdata = bitd_pkg::DATA_W'(cfg_q.release_offset);
			bitd_pkg::REG_DEBOUNCE_US:    prdata = bitd_pkg::DATA_W'(cfg_q.debounce_us);
			default:                      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	logic v_s1, v_s2;
	logic out_ready, s2_en, s1_en;
	logic in_acc, item_ok, take;

	// each stage moves when the one after it is empty or moving
	assign out_ready = !out_valid || !out_stall;
	assign s2_en     = !v_s2 || out_ready;
	assign s1_en     = !v_s1 || s2_en;
	assign in_stall  = !s1_en;

	assign in_acc  = in_valid && !in_stall;
	// zero samples and channels beyond the configured count leave no trace
	assign item_ok = (sample != '0) && (int'(channel) < CHANNELS);
	assign take    = in_acc && item_ok;

	// ---------------------------------------------------------------- stage 0: positions
	logic [CH_W-1:0]   ch_in;
	logic [POS_W-1:0]  pos_q [CHANNELS];
	logic [CHANNELS-1:0] full_q;
	logic [ADDR_W-1:0] rd_addr;

	assign ch_in   = CH_W'(channel);
	assign rd_addr = {ch_in, pos_q[ch_in]};

	// full_q marks a channel whose window has wrapped once: from then on
	// every entry read has been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= '0;
			end
			full_q <= '0;
		end else if (take) begin
			pos_q[ch_in] <= POS_W'(pos_q[ch_in] + 1'b1);
			if (&pos_q[ch_in]) begin
				full_q[ch_in] <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- window memory
	logic [bitd_pkg::SAMPLE_W-1:0] win_mem [MEM_DEPTH];
	logic [bitd_pkg::SAMPLE_W-1:0] rd_s1;
	logic [CH_W-1:0]               ch_s1;
	logic [bitd_pkg::SAMPLE_W-1:0] sample_s1;
	logic [bitd_pkg::TIME_W-1:0]   time_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic                          full_s1;
	logic                          commit1;

	// oldest entry read at request time; the same slot of a channel is not
	// revisited before its pending write lands since the window holds two or more
	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1 <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (commit1) begin
			win_mem[addr_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			ch_s1     <= ch_in;
			sample_s1 <= sample;
			time_s1   <= time_us;
			addr_s1   <= rd_addr;
			full_s1   <= full_q[ch_in];
		end
	end

	// ---------------------------------------------------------------- stage 1: running sum
	logic [SUM_W-1:0]              sum_q [CHANNELS];
	logic [bitd_pkg::SAMPLE_W-1:0] oldest;
	logic [SUM_W-1:0]              new_sum;

	assign commit1 = s2_en && v_s1;
	assign oldest  = full_s1 ? rd_s1 : '0;
	assign new_sum = sum_q[ch_s1] - SUM_W'(oldest) + SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
			end
		end else if (commit1) begin
			sum_q[ch_s1] <= new_sum;
		end
	end

	logic [CH_W-1:0]               ch_s2;
	logic [bitd_pkg::SAMPLE_W-1:0] sample_s2;
	logic [bitd_pkg::TIME_W-1:0]   time_s2;
	logic [bitd_pkg::SAMPLE_W-1:0] avg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_en) begin
			v_s2 <= v_s1;
		end
	end

	// average is the sum shifted down by POS_W bits, that is divided by the window depth
	always_ff @(posedge clk) begin
		if (s2_en) begin
			ch_s2     <= ch_s1;
			sample_s2 <= sample_s1;
			time_s2   <= time_s1;
			avg_s2    <= new_sum[SUM_W-1:POS_W];
		end
	end

	// ---------------------------------------------------------------- stage 2: thresholds
	bitd_pkg::ev_t ev;
	logic          commit2;

	assign commit2 = out_ready && v_s2;

	bitd_event #(
		.CHANNELS(CHANNELS),
		.CH_W(CH_W)
	) u_event (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.commit(commit2),
		.ch(ch_s2),
		.sample(sample_s2),
		.avg(avg_s2),
		.now(time_s2),
		.ev(ev)
	);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			out_channel   <= ch_s2[0];
			current_value <= sample_s2;
			average       <= avg_s2;
			impact        <= ev.impact;
			release_res   <= ev.release_ev;
		end
	end

	// ---------------------------------------------------------------- assertions
	// impact wins, so both events never show together
	a_ev_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(impact && release_res))
		else $error("impact and release reported together");

	// a dropped zero sample must not enter the pipeline
	a_zero_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sample == '0) |=> !v_s1)
		else $error("zero sample entered the pipeline");

	// fill flags only ever set until the next reset
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(($past(full_q) & ~full_q) == '0))
		else $error("window fill flag cleared without reset");

	// the window write follows the read of the same request into stage one
	a_commit_order: assert property (@(posedge clk) disable iff (!arst_n)
		commit1 |-> v_s1 && s2_en)
		else $error("window write without a stage one request");

endmodule
